>>> hw/rtl/trw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trw_pkg: shared types for the TCP receive window trim unit
// Item formats for the segment and result channels, and the record that
// passes from the head trim stages to the tail trim stages.
// ----------------------------------------------------------------------------
package trw_pkg;

	localparam int SEQ_W  = 32;
	localparam int LEN_W  = 16;
	localparam int OCC_W  = 17;
	localparam int DUP_W  = 17;
	localparam int DIFF_W = SEQ_W + 2;

	// One incoming segment with the receiver's window.
	typedef struct packed {
		logic [SEQ_W-1:0] seg_seq;
		logic [LEN_W-1:0] seg_length;
		logic             syn_flag;
		logic             fin_flag;
		logic [SEQ_W-1:0] rcv_next;
		logic [LEN_W-1:0] rcv_window;
	} seg_in_t;

	// One verdict for a segment.
	typedef struct packed {
		logic             accepted;
		logic [SEQ_W-1:0] out_seq;
		logic [LEN_W-1:0] out_length;
		logic             out_syn;
		logic             out_fin;
		logic [LEN_W-1:0] head_drop;
		logic [DUP_W-1:0] dup_bytes;
	} seg_out_t;

	// Segment after the head trim, before the right window edge is applied.
	typedef struct packed {
		logic             accepted;
		logic [SEQ_W-1:0] seq;
		logic [LEN_W-1:0] length;
		logic             syn;
		logic             fin;
		logic [LEN_W-1:0] wnd;
		logic [OCC_W-1:0] occ_len;
		logic [LEN_W-1:0] head;
		logic [DUP_W-1:0] dup_head;
		logic [SEQ_W-1:0] diff_next;
	} head_trim_t;

endpackage

>>> hw/rtl/trw_tail_trim.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trw_tail_trim: right window edge trim and result register
// Two stages: the signed overhang past the window edge, then the clamp,
// the final length, the duplicate count and the verdict mux.
// ----------------------------------------------------------------------------
module trw_tail_trim import trw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       vld,
	input  head_trim_t trim,
	output logic       done,
	output seg_out_t   result
);

	logic                     vld_s4;
	head_trim_t               trim_s4;
	logic signed [DIFF_W-1:0] over_s4;

	logic signed [DIFF_W-1:0] over_d;
	logic                     tail_pos;
	logic                     tail_clamp;
	logic [LEN_W-1:0]         tail;
	seg_out_t                 res_d;

	// Overhang = (seq - next) as signed + length - window.
	assign over_d = $signed({{2{trim.diff_next[SEQ_W-1]}}, trim.diff_next})
		+ $signed({{(DIFF_W-LEN_W){1'b0}}, trim.length})
		- $signed({{(DIFF_W-LEN_W){1'b0}}, trim.wnd});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		trim_s4 <= trim;
		over_s4 <= over_d;
	end

	// Clamp the overhang to the kept payload; a trimmed tail takes the FIN.
	assign tail_pos   = !over_s4[DIFF_W-1] && (over_s4 != '0);
	assign tail_clamp = over_s4[DIFF_W-2:0] > {{(DIFF_W-1-LEN_W){1'b0}}, trim_s4.length};
	assign tail       = !tail_pos ? '0 : (tail_clamp ? trim_s4.length : over_s4[LEN_W-1:0]);

	always_comb begin
		res_d = '0;
		if (trim_s4.accepted) begin
			res_d.accepted   = 1'b1;
			res_d.out_seq    = trim_s4.seq;
			res_d.out_length = trim_s4.length - tail;
			res_d.out_syn    = trim_s4.syn;
			res_d.out_fin    = trim_s4.fin && !tail_pos;
			res_d.head_drop  = trim_s4.head;
			res_d.dup_bytes  = trim_s4.dup_head + {{(DUP_W-LEN_W){1'b0}}, tail};
		end else begin
			res_d.dup_bytes  = trim_s4.occ_len;
		end
	end

	// Result register, shown for one cycle under the done strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		result <= res_d;
	end

endmodule

>>> hw/rtl/tcp_receive_window_trim_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_receive_window_trim_unit: segment acceptability test and trim
// Decides whether a segment touches the receive window and trims its
// duplicate head and out-of-window tail, all in modulo 2^32 sequence space.
// ----------------------------------------------------------------------------
// A segment item is taken in any cycle that start is high; busy is always
// low, so one item per cycle is sustained. Each item yields exactly one
// result, shown for a single cycle with done high. The receiver cannot
// stall the pipeline and must take every result as it appears. An item
// passes through five register stages: sequence differences, window
// tests with the head count, head trim, tail overhang, and the result
// register. No state is kept between items.
module tcp_receive_window_trim_unit import trw_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  seg_in_t  segment,
	output logic     done,
	output seg_out_t result
);

	// Stage 1 registers.
	logic             vld_s1;
	logic [SEQ_W-1:0] seq_s1, next_s1, d_sn_s1, d_ns_s1, last_s1;
	logic [LEN_W-1:0] length_s1, wnd_s1;
	logic             syn_s1, fin_s1, pos_s1, take_s1;
	logic [OCC_W-1:0] occ_s1;

	// Stage 2 registers.
	logic             vld_s2;
	logic             accept_s2;
	logic [SEQ_W-1:0] seq_s2, d_sn_s2;
	logic [LEN_W-1:0] length_s2, wnd_s2, head_s2;
	logic             syn_s2, fin_s2, take_s2;
	logic [OCC_W-1:0] occ_s2;
	logic [DUP_W-1:0] dup_s2;

	// Stage 3 registers.
	logic       vld_s3;
	head_trim_t trim_s3;

	logic [OCC_W-1:0] occ_d;
	logic [SEQ_W-1:0] d_ns_d;
	logic             start_in, last_in, straddle, accept_d;
	logic [LEN_W-1:0] wnd_m1;
	logic [SEQ_W-1:0] last_off;
	logic             head_clamp;
	logic [SEQ_W-1:0] head_rem;
	logic [LEN_W-1:0] head_d;

	assign busy = 1'b0;

	// Occupied sequence length and the two sequence differences.
	assign occ_d  = {1'b0, segment.seg_length} + OCC_W'(segment.syn_flag)
		+ OCC_W'(segment.fin_flag);
	assign d_ns_d = segment.rcv_next - segment.seg_seq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		seq_s1    <= segment.seg_seq;
		next_s1   <= segment.rcv_next;
		length_s1 <= segment.seg_length;
		wnd_s1    <= segment.rcv_window;
		syn_s1    <= segment.syn_flag;
		fin_s1    <= segment.fin_flag;
		occ_s1    <= occ_d;
		d_sn_s1   <= segment.seg_seq - segment.rcv_next;
		d_ns_s1   <= d_ns_d;
		last_s1   <= segment.seg_seq + SEQ_W'(occ_d) - SEQ_W'(1);
		pos_s1    <= !d_ns_d[SEQ_W-1] && (d_ns_d != '0);
		take_s1   <= segment.syn_flag && !d_ns_d[SEQ_W-1] && (d_ns_d != '0);
	end

	// Window tests: start in window, last octet in window, or a straddle.
	assign wnd_m1   = wnd_s1 - LEN_W'(1);
	assign last_off = last_s1 - next_s1;
	assign start_in = d_sn_s1 <= {{(SEQ_W-LEN_W){1'b0}}, wnd_m1};
	assign last_in  = (occ_s1 != '0) && (last_off <= {{(SEQ_W-LEN_W){1'b0}}, wnd_m1});
	assign straddle = (occ_s1 != '0)
		&& (d_ns_s1 <= SEQ_W'(occ_s1 - OCC_W'(1)));

	// A closed window passes only an empty in-order segment.
	assign accept_d = (wnd_s1 == '0) ? ((d_sn_s1 == '0) && (occ_s1 == '0))
		: (start_in || last_in || straddle);

	// Duplicate head payload, after a SYN has used up one octet.
	assign head_clamp = d_ns_s1 > SEQ_W'({1'b0, length_s1} + OCC_W'(take_s1));
	assign head_rem   = d_ns_s1 - SEQ_W'(take_s1);
	assign head_d     = !pos_s1 ? '0 : (head_clamp ? length_s1 : head_rem[LEN_W-1:0]);

	always_ff @(posedge clk) begin
		accept_s2 <= accept_d;
		seq_s2    <= seq_s1;
		d_sn_s2   <= d_sn_s1;
		length_s2 <= length_s1;
		wnd_s2    <= wnd_s1;
		head_s2   <= head_d;
		syn_s2    <= syn_s1 && !take_s1;
		fin_s2    <= fin_s1;
		take_s2   <= take_s1;
		occ_s2    <= occ_s1;
		dup_s2    <= pos_s1 ? d_ns_s1[DUP_W-1:0] : '0;
	end

	// Apply the head trim to sequence, length and offset from rcv_next.
	always_ff @(posedge clk) begin
		trim_s3.accepted  <= accept_s2;
		trim_s3.seq       <= seq_s2 + SEQ_W'(take_s2) + SEQ_W'(head_s2);
		trim_s3.diff_next <= d_sn_s2 + SEQ_W'(take_s2) + SEQ_W'(head_s2);
		trim_s3.length    <= length_s2 - head_s2;
		trim_s3.syn       <= syn_s2;
		trim_s3.fin       <= fin_s2;
		trim_s3.wnd       <= wnd_s2;
		trim_s3.occ_len   <= occ_s2;
		trim_s3.head      <= head_s2;
		trim_s3.dup_head  <= dup_s2;
	end

	trw_tail_trim u_tail (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (vld_s3),
		.trim   (trim_s3),
		.done   (done),
		.result (result)
	);

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for the TCP receive window trim unit
// Segments drawn from directed corner cases and from random traffic around
// the window edges are fed through the unit. Every verdict is checked field
// by field against a behavioral predictor kept in this bench.
// ----------------------------------------------------------------------------
module tb_top;
	import trw_pkg::*;

	localparam int CLK_HALF   = 10;
	localparam int RESET_CYC  = 9;
	localparam int PIPE_DEPTH = 5;
	localparam int N_RANDOM   = 1400;
	localparam int MAX_CYCLES = 300000;
	localparam int MAX_REPORT = 10;

	// One segment waiting to be offered, with its pacing controls.
	typedef struct {
		seg_in_t     seg;
		bit          drain_first;
		int unsigned idle_pct;
	} pending_seg_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	seg_in_t  segment = '0;
	logic     busy;
	logic     done;
	seg_out_t result;

	pending_seg_t segment_q[$];
	seg_out_t     verdict_q[$];
	int           in_flight = 0;
	int           cycle_cnt = 0;
	int           n_sent = 0;
	int           n_checked = 0;
	int           n_mismatch = 0;
	int           n_accepted = 0;
	int           n_dropped = 0;
	int           n_trimmed = 0;

	tcp_receive_window_trim_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.segment(segment),
		.done   (done),
		.result (result)
	);

	// Clock generation.
	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// True when x lies in [lo, hi] in modulo 2^32 sequence space.
	function automatic bit in_seq_range(input logic [31:0] x, input logic [31:0] lo,
			input logic [31:0] hi);
		logic [31:0] off;
		logic [31:0] span;
		off  = x - lo;
		span = hi - lo;
		return off <= span;
	endfunction

	// Signed distance a - b in sequence space.
	function automatic longint seq_gap(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return longint'($signed(d));
	endfunction

	// Expected verdict for one segment: acceptability, then head and tail trim.
	function automatic seg_out_t trim_verdict(input seg_in_t s);
		logic [31:0] seq;
		logic [31:0] hi;
		logic [31:0] last;
		logic [16:0] occ;
		logic        syn;
		logic        fin;
		bit          ok;
		longint      len;
		longint      cnt;
		longint      dup;
		longint      head;
		seg_out_t    v;
		v    = '0;
		seq  = s.seg_seq;
		syn  = s.syn_flag;
		fin  = s.fin_flag;
		len  = s.seg_length;
		occ  = 17'(s.seg_length) + 17'(s.syn_flag) + 17'(s.fin_flag);
		ok   = 1'b0;
		dup  = 0;
		head = 0;

		// A closed window only admits an empty in-order segment, untouched.
		if (s.rcv_window == '0) begin
			if (seq == s.rcv_next && occ == '0) begin
				v.accepted = 1'b1;
				v.out_seq  = seq;
				return v;
			end
		end else begin
			hi   = s.rcv_next + 32'(s.rcv_window) - 32'd1;
			last = seq + 32'(occ) - 32'd1;
			ok   = in_seq_range(seq, s.rcv_next, hi) ||
				(occ != '0 && (in_seq_range(last, s.rcv_next, hi) ||
				in_seq_range(s.rcv_next, seq, last)));
		end

		// A dropped segment counts its whole occupied length as duplicate.
		if (!ok) begin
			v.dup_bytes = occ;
			return v;
		end

		// Head trim: SYN is consumed first, then leading payload.
		cnt = seq_gap(s.rcv_next, seq);
		if (cnt > 0) begin
			dup = cnt;
			if (syn) begin
				syn = 1'b0;
				seq = seq + 32'd1;
				cnt--;
			end
			if (cnt > 0) begin
				if (cnt > len)
					cnt = len;
				head = cnt;
				seq  = seq + 32'(head);
				len  = len - head;
			end
		end

		// Tail trim: payload past the right window edge goes, and FIN with it.
		cnt = seq_gap(seq, s.rcv_next) + len - longint'(s.rcv_window);
		if (cnt > 0) begin
			if (cnt > len)
				cnt = len;
			dup = dup + cnt;
			len = len - cnt;
			fin = 1'b0;
		end

		v.accepted   = 1'b1;
		v.out_seq    = seq;
		v.out_length = 16'(len);
		v.out_syn    = syn;
		v.out_fin    = fin;
		v.head_drop  = 16'(head);
		v.dup_bytes  = 17'(dup);
		return v;
	endfunction

	function automatic seg_in_t mk_seg(input logic [31:0] seq, input logic [15:0] len,
			input logic syn, input logic fin, input logic [31:0] nxt,
			input logic [15:0] wnd);
		seg_in_t s;
		s.seg_seq    = seq;
		s.seg_length = len;
		s.syn_flag   = syn;
		s.fin_flag   = fin;
		s.rcv_next   = nxt;
		s.rcv_window = wnd;
		return s;
	endfunction

	// Random segment, mostly placed near the window edges so that trims happen.
	function automatic seg_in_t random_seg();
		seg_in_t     s;
		int unsigned pick;
		int          occ;
		int          off;
		pick         = $urandom_range(99);
		s.seg_seq    = $urandom;
		s.seg_length = 16'($urandom);
		s.syn_flag   = 1'($urandom);
		s.fin_flag   = 1'($urandom);
		s.rcv_next   = $urandom;
		s.rcv_window = 16'($urandom);
		if (pick < 10)
			return s;

		// Window sizes: closed, full, small, or anything.
		pick = $urandom_range(99);
		if (pick < 6)
			s.rcv_window = '0;
		else if (pick < 16)
			s.rcv_window = 16'hFFFF;
		else if (pick < 70)
			s.rcv_window = 16'($urandom_range(1, 2000));

		// Payload sizes: empty, packet sized, or anything.
		pick = $urandom_range(99);
		if (pick < 10)
			s.seg_length = '0;
		else if (pick < 75)
			s.seg_length = 16'($urandom_range(1, 1500));
		s.syn_flag = ($urandom_range(3) == 0);
		s.fin_flag = ($urandom_range(3) == 0);

		// Place the start so that the segment lands around the window.
		occ = int'(s.seg_length) + int'(s.syn_flag) + int'(s.fin_flag);
		if (s.rcv_window == '0 && $urandom_range(1) == 1) begin
			s.seg_seq = s.rcv_next;
			if ($urandom_range(1) == 1) begin
				s.seg_length = '0;
				s.syn_flag   = 1'b0;
				s.fin_flag   = 1'b0;
			end
		end else if ($urandom_range(19) == 0) begin
			s.seg_seq = s.rcv_next;
		end else begin
			off       = int'($urandom_range(0, occ + int'(s.rcv_window) + 32)) - (occ + 16);
			s.seg_seq = s.rcv_next + 32'(off);
		end
		return s;
	endfunction

	task automatic queue_segment(input seg_in_t s, input bit drain, input int unsigned pct);
		pending_seg_t p;
		p.seg         = s;
		p.drain_first = drain;
		p.idle_pct    = pct;
		segment_q.push_back(p);
	endtask

	// Driver: offer the head of the pending queue, with idle gaps and drains.
	always @(posedge clk) begin
		pending_seg_t nxt_seg;
		bit           go;
		go = 1'b0;
		if (arst_n) begin
			if (start && !busy) begin
				void'(segment_q.pop_front());
				n_sent++;
			end
			if (segment_q.size() > 0) begin
				nxt_seg = segment_q[0];
				go      = 1'b1;
				// A drain mark holds off until every verdict has come back.
				if (nxt_seg.drain_first) begin
					if (!start && in_flight == 0) begin
						nxt_seg.drain_first = 1'b0;
						segment_q[0]        = nxt_seg;
					end else begin
						go = 1'b0;
					end
				end
				if (go && $urandom_range(99) < nxt_seg.idle_pct)
					go = 1'b0;
				if (go)
					segment <= nxt_seg.seg;
			end
		end
		start <= go;
	end

	// Monitor: predict on each accepted item and check each verdict.
	always @(posedge clk) begin
		seg_out_t want;
		bit       bad;
		int       delta;
		delta = 0;
		if (arst_n) begin
			if (start && !busy) begin
				verdict_q.push_back(trim_verdict(segment));
				delta++;
			end
			if (done) begin
				if (verdict_q.size() == 0) begin
					n_mismatch++;
					if (n_mismatch <= MAX_REPORT)
						$display("[%0t] unexpected verdict: %p", $time, result);
				end else begin
					want = verdict_q.pop_front();
					delta--;
					n_checked++;
					bad = (result.accepted   !== want.accepted)   ||
						(result.out_seq    !== want.out_seq)    ||
						(result.out_length !== want.out_length) ||
						(result.out_syn    !== want.out_syn)    ||
						(result.out_fin    !== want.out_fin)    ||
						(result.head_drop  !== want.head_drop)  ||
						(result.dup_bytes  !== want.dup_bytes);
					if (bad) begin
						n_mismatch++;
						if (n_mismatch <= MAX_REPORT) begin
							$display("[%0t] verdict mismatch", $time);
							$display("  expected: %p", want);
							$display("  actual:   %p", result);
						end
					end
					if (!want.accepted)
						n_dropped++;
					else begin
						n_accepted++;
						if (want.dup_bytes != '0)
							n_trimmed++;
					end
				end
			end
			in_flight <= in_flight + delta;
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == MAX_CYCLES) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Stimulus plan, reset, and the end of the run.
	initial begin
		int unsigned pct;
		bit          drain;

		// Directed corner cases, sent back to back.
		queue_segment(mk_seg(32'd1000, 16'd0, 1'b0, 1'b0, 32'd1000, 16'd0), 1'b0, 0);
		queue_segment(mk_seg(32'd1000, 16'd0, 1'b1, 1'b0, 32'd1000, 16'd0), 1'b0, 0);
		queue_segment(mk_seg(32'd1000, 16'd10, 1'b0, 1'b0, 32'd1000, 16'd0), 1'b0, 0);
		queue_segment(mk_seg(32'd999, 16'd0, 1'b0, 1'b0, 32'd1000, 16'd0), 1'b0, 0);
		queue_segment(mk_seg(32'd1000, 16'd100, 1'b0, 1'b0, 32'd1000, 16'd500), 1'b0, 0);
		// Starts on the last window octet, so the tail and its FIN go.
		queue_segment(mk_seg(32'd1499, 16'd10, 1'b0, 1'b1, 32'd1000, 16'd500), 1'b0, 0);
		queue_segment(mk_seg(32'd1500, 16'd10, 1'b0, 1'b0, 32'd1000, 16'd500), 1'b0, 0);
		queue_segment(mk_seg(32'd1500, 16'd0, 1'b0, 1'b0, 32'd1000, 16'd500), 1'b0, 0);
		// Old duplicate that ends before the window.
		queue_segment(mk_seg(32'd900, 16'd50, 1'b0, 1'b0, 32'd1000, 16'd500), 1'b0, 0);
		// Straddles the left edge with a SYN that is trimmed first.
		queue_segment(mk_seg(32'd900, 16'd200, 1'b1, 1'b0, 32'd1000, 16'd500), 1'b0, 0);
		queue_segment(mk_seg(32'd999, 16'd10, 1'b1, 1'b0, 32'd1000, 16'd500), 1'b0, 0);
		// Only the FIN lands in the window.
		queue_segment(mk_seg(32'd990, 16'd10, 1'b0, 1'b1, 32'd1000, 16'd500), 1'b0, 0);
		queue_segment(mk_seg(32'd800, 16'd1000, 1'b1, 1'b1, 32'd1000, 16'd500), 1'b0, 0);
		// Sequence space wraps through zero.
		queue_segment(mk_seg(32'hFFFF_FFF0, 16'd100, 1'b0, 1'b0, 32'h10, 16'd1000), 1'b0, 0);
		queue_segment(mk_seg(32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1, 32'h0, 16'hFFFF), 1'b0, 0);
		queue_segment(mk_seg(32'h0, 16'h0, 1'b0, 1'b0, 32'h0, 16'h0), 1'b0, 0);
		queue_segment(mk_seg(32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 16'hFFFF),
			1'b0, 0);
		// Differences at the sign boundary of sequence arithmetic.
		queue_segment(mk_seg(32'h8000_0000, 16'd10, 1'b0, 1'b0, 32'h0, 16'd100), 1'b0, 0);
		queue_segment(mk_seg(32'h1, 16'd10, 1'b0, 1'b0, 32'h8000_0000, 16'd100), 1'b0, 0);
		queue_segment(mk_seg(32'd1000, 16'd0, 1'b0, 1'b1, 32'd1000, 16'd1), 1'b0, 0);
		queue_segment(mk_seg(32'd1000, 16'd5, 1'b0, 1'b0, 32'd1000, 16'd1), 1'b0, 0);
		queue_segment(mk_seg(32'd995, 16'd5, 1'b0, 1'b0, 32'd1000, 16'd10), 1'b0, 0);
		queue_segment(mk_seg(32'd995, 16'd5, 1'b0, 1'b1, 32'd1000, 16'd10), 1'b0, 0);

		// Random traffic in phases of pacing; the receiver cannot stall, so
		// only the sender's gaps vary. Each phase opens with a full drain.
		for (int i = 0; i < N_RANDOM; i++) begin
			case (i * 4 / N_RANDOM)
				0:       pct = 0;
				1:       pct = 71;
				2:       pct = 0;
				default: pct = 12;
			endcase
			drain = (i % (N_RANDOM / 4)) == 0;
			queue_segment(random_seg(), drain, pct);
		end

		repeat (RESET_CYC) @(posedge clk);
		arst_n <= 1'b1;

		// Sample the bench state away from the active edge.
		@(negedge clk);
		while (segment_q.size() != 0 || start || in_flight != 0)
			@(negedge clk);
		repeat (PIPE_DEPTH * 4) @(negedge clk);

		$display("Sent %0d segments, checked %0d verdicts, %0d mismatches.",
			n_sent, n_checked, n_mismatch);
		$display("Verdicts: %0d accepted (%0d with trimmed bytes), %0d dropped.",
			n_accepted, n_trimmed, n_dropped);
		if (n_mismatch == 0 && verdict_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/trw_pkg.sv
hw/rtl/trw_tail_trim.sv
hw/rtl/tcp_receive_window_trim_unit.sv
sim/tb_top.sv
